[hw/rtl/gpg_pkg.sv]
// ----------------------------------------------------------------------------
// gpg_pkg
// Shared types, constants and palette for the gradient pixel generator.
// ----------------------------------------------------------------------------
package gpg_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int PROJ_W     = 32;
  localparam int COLOR_W    = 17;
  localparam int NOISE_W    = 7;
  localparam int T_W        = 17;
  localparam int DIV_STEPS  = 16;
  localparam int MOD_STEPS  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

  // register reset values
  localparam logic [12:0] RST_TIME   = 13'd3072;
  localparam logic [4:0]  RST_GRAIN  = 5'd5;
  localparam logic [15:0] RST_DIR_X  = 16'd0;
  localparam logic [15:0] RST_DIR_Y  = 16'd16384;
  localparam logic [11:0] RST_WIDTH  = 12'd1920;
  localparam logic [11:0] RST_HEIGHT = 12'd1080;

  localparam logic [31:0] SEED_INIT  = 32'd1337;
  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_INC    = 32'd12345;
  localparam logic [21:0] DIV6_RECIP = 22'd2796203;   // ceil(2^24 / 6)
  localparam logic [12:0] TIME_MAX   = 13'd6144;
  localparam logic [PROJ_W-1:0] RANGE_ONE = PROJ_W'(16384);

  typedef struct packed {
    logic [12:0] time_of_day;
    logic [4:0]  grain;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic [PROJ_W-1:0]            num;
    logic [PROJ_W-1:0]            rng;
    logic [2:0][COLOR_W-1:0]      top;
    logic [2:0][COLOR_W-1:0]      bot;
    logic [NOISE_W-1:0]           noise;
    logic                         eol;
    logic                         eof;
  } entry_t;

  // palette color {r,g,b}; sel_bot picks the bottom palette
  function automatic logic [23:0] pal_rgb(input logic sel_bot, input logic [1:0] seg);
    logic [23:0] c;
    unique case ({sel_bot, seg})
      3'b000: c = {8'd10,  8'd10,  8'd25};
      3'b001: c = {8'd200, 8'd100, 8'd80};
      3'b010: c = {8'd100, 8'd200, 8'd255};
      3'b011: c = {8'd80,  8'd40,  8'd100};
      3'b100: c = {8'd5,   8'd5,   8'd15};
      3'b101: c = {8'd100, 8'd50,  8'd60};
      3'b110: c = {8'd180, 8'd230, 8'd255};
      3'b111: c = {8'd250, 8'd120, 8'd80};
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/gpg_queue.sv]
// ----------------------------------------------------------------------------
// gpg_queue
// Two-entry queue of classified pixel jobs between front and back.
// ----------------------------------------------------------------------------
module gpg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  gpg_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output gpg_pkg::entry_t entry_o,
  output logic            empty_o
);

  gpg_pkg::entry_t mem_r [gpg_pkg::QUEUE_DEPTH];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == 2'(gpg_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_r == 2'd0);
  assign entry_o = mem_r[rp_r];

  // advance pointers and fill count
  always_comb begin
    wp_nxt  = push_i ? ~wp_r : wp_r;
    rp_nxt  = pop_i ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wp_r] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push_i |-> !full_o)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop_i |-> !empty_o)
    else $error("queue pop while empty");

endmodule

[hw/rtl/gpg_front.sv]
// ----------------------------------------------------------------------------
// gpg_front
// Accepts requests, runs frame setup, forms projection and noise per pixel.
// ----------------------------------------------------------------------------
module gpg_front #(
  parameter int MAX_WIDTH  = gpg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gpg_pkg::DEF_MAX_HEIGHT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gpg_pkg::cfg_t   cfg_i,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_frame_start,
  output logic            push_o,
  output gpg_pkg::entry_t entry_o,
  input  logic            full_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = gpg_pkg::PROJ_W;
  localparam int KW = gpg_pkg::COLOR_W;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_SETUP = 3'd1;
  localparam logic [2:0] F_MUL   = 3'd2;
  localparam logic [2:0] F_MOD   = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;
  localparam logic [3:0] STEP_LAST = 4'd13;

  logic [2:0]           state_r, state_nxt;
  logic [3:0]           step_r, step_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [31:0]          seed_r, seed_nxt;
  logic [5:0][KW-1:0]   color_r, color_nxt;
  logic signed [PW-1:0] mn_r, mn_nxt;
  logic [PW-1:0]        rng_r, rng_nxt;
  logic signed [PW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [PW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [20:0]   cprod_r, cprod_nxt;
  logic [14:0]          rbits_r, rbits_nxt;
  logic [5:0]           rem_r, rem_nxt;
  logic [PW-1:0]        num_r, num_nxt;

  logic [12:0] w13, h13, tm, seg_base;
  logic [1:0]  seg, seg_n;
  logic [10:0] f;
  logic [3:0]  sk;
  logic [2:0]  k;
  logic [1:0]  ch;
  logic        sel_bot;
  logic [23:0] rgb1, rgb2;
  logic [7:0]  c1, c2;
  logic signed [20:0] diff_e, f_e;
  logic [19:0] cmag;
  logic [41:0] qprod;
  logic signed [18:0] qs, cval;
  logic signed [PW-1:0] dxe, dye, we, he, c2s, mn_c, mx_c, p;
  logic [PW-1:0] rng_c;
  logic [31:0] seed_adv;
  logic [6:0]  rem2;
  logic [5:0]  divisor;
  logic        eol, eof;

  // saturate frame size
  always_comb begin
    if (cfg_i.frame_width == 12'd0) w13 = 13'd1;
    else if ({1'b0, cfg_i.frame_width} > 13'(MAX_WIDTH)) w13 = 13'(MAX_WIDTH);
    else w13 = {1'b0, cfg_i.frame_width};
    if (cfg_i.frame_height == 12'd0) h13 = 13'd1;
    else if ({1'b0, cfg_i.frame_height} > 13'(MAX_HEIGHT)) h13 = 13'(MAX_HEIGHT);
    else h13 = {1'b0, cfg_i.frame_height};
  end

  assign eol = (14'(col_r) + 14'd1) >= {1'b0, w13};
  assign eof = eol && ((14'(row_r) + 14'd1) >= {1'b0, h13});

  // palette segment and blend weight
  always_comb begin
    tm = (cfg_i.time_of_day > gpg_pkg::TIME_MAX) ? gpg_pkg::TIME_MAX : cfg_i.time_of_day;
    priority if (tm >= 13'd4608) begin
      seg = 2'd3; seg_base = 13'd4608;
    end else if (tm >= 13'd3072) begin
      seg = 2'd2; seg_base = 13'd3072;
    end else if (tm >= 13'd1536) begin
      seg = 2'd1; seg_base = 13'd1536;
    end else begin
      seg = 2'd0; seg_base = 13'd0;
    end
    f     = 11'(tm - seg_base);
    seg_n = seg + 2'd1;
  end

  // color step decode: two steps per color, top colors first
  always_comb begin
    sk      = step_r - 4'd2;
    k       = sk[3:1];
    sel_bot = (k >= 3'd3);
    ch      = sel_bot ? 2'(k - 3'd3) : k[1:0];
    rgb1    = gpg_pkg::pal_rgb(sel_bot, seg);
    rgb2    = gpg_pkg::pal_rgb(sel_bot, seg_n);
    unique case (ch)
      2'd0:    begin c1 = rgb1[23:16]; c2 = rgb2[23:16]; end
      2'd1:    begin c1 = rgb1[15:8];  c2 = rgb2[15:8];  end
      default: begin c1 = rgb1[7:0];   c2 = rgb2[7:0];   end
    endcase
    diff_e = 21'(c2) - 21'(c1);
    f_e    = 21'(f);
    // truncating divide by six through the reciprocal
    cmag   = cprod_r[20] ? 20'(-cprod_r) : 20'(cprod_r);
    qprod  = 42'(cmag) * 42'(gpg_pkg::DIV6_RECIP);
    qs     = cprod_r[20] ? -19'(qprod[40:24]) : 19'(qprod[40:24]);
    cval   = $signed({3'b0, c1, 8'd0}) + qs;
  end

  // frame corners and extent
  always_comb begin
    dxe  = {{(PW-16){cfg_i.dir_x[15]}}, cfg_i.dir_x};
    dye  = {{(PW-16){cfg_i.dir_y[15]}}, cfg_i.dir_y};
    we   = PW'(w13);
    he   = PW'(h13);
    c2s  = cx_r + cy_r;
    mn_c = '0;
    mx_c = '0;
    if (cx_r < mn_c) mn_c = cx_r;
    if (cy_r < mn_c) mn_c = cy_r;
    if (c2s < mn_c)  mn_c = c2s;
    if (cx_r > mx_c) mx_c = cx_r;
    if (cy_r > mx_c) mx_c = cy_r;
    if (c2s > mx_c)  mx_c = c2s;
    rng_c = PW'(mx_c - mn_c);
    if (rng_c < PW'(2)) rng_c = gpg_pkg::RANGE_ONE;
  end

  // noise and projection helpers
  always_comb begin
    seed_adv = seed_r * gpg_pkg::LCG_MUL + gpg_pkg::LCG_INC;
    divisor  = {cfg_i.grain, 1'b1};
    rem2     = {rem_r, rbits_r[14]};
    p        = px_r + py_r;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    seed_nxt  = seed_r;
    color_nxt = color_r;
    mn_nxt    = mn_r;
    rng_nxt   = rng_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    cprod_nxt = cprod_r;
    rbits_nxt = rbits_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    push_o    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          step_nxt  = 4'd0;
          state_nxt = in_frame_start ? F_SETUP : F_MUL;
        end
      end
      F_SETUP: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd0) begin
          cx_nxt = we * dxe;
          cy_nxt = he * dye;
        end else if (step_r == 4'd1) begin
          mn_nxt  = mn_c;
          rng_nxt = rng_c;
        end else if (!sk[0]) begin
          cprod_nxt = diff_e * f_e;
        end else begin
          color_nxt[k] = KW'(cval);
        end
        if (step_r == STEP_LAST) begin
          seed_nxt  = gpg_pkg::SEED_INIT;
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        px_nxt = PW'(col_r) * dxe;
        py_nxt = PW'(row_r) * dye;
        if (cfg_i.grain != 5'd0) begin
          seed_nxt = seed_adv;
        end
        rbits_nxt = seed_adv[30:16];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = F_MOD;
      end
      F_MOD: begin
        // one remainder bit per cycle
        rem_nxt   = (rem2 >= {1'b0, divisor}) ? 6'(rem2 - {1'b0, divisor}) : rem2[5:0];
        rbits_nxt = {rbits_r[13:0], 1'b0};
        num_nxt   = (p > mn_r) ? PW'(p - mn_r) : '0;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == 4'(gpg_pkg::MOD_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o = 1'b1;
          if (eol) begin
            col_nxt = '0;
            row_nxt = eof ? '0 : row_r + RW'(1);
          end else begin
            col_nxt = col_r + CW'(1);
          end
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // hold pixel job
  always_comb begin
    entry_o.num   = num_r;
    entry_o.rng   = rng_r;
    entry_o.top   = color_r[2:0];
    entry_o.bot   = color_r[5:3];
    entry_o.noise = (cfg_i.grain == 5'd0) ? '0 : 7'(rem_r) - 7'(cfg_i.grain);
    entry_o.eol   = eol;
    entry_o.eof   = eof;
  end

  assign in_stall = (state_r != F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      seed_r  <= gpg_pkg::SEED_INIT;
      color_r <= '0;
      mn_r    <= '0;
      rng_r   <= gpg_pkg::RANGE_ONE;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      seed_r  <= seed_nxt;
      color_r <= color_nxt;
      mn_r    <= mn_nxt;
      rng_r   <= rng_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    cprod_r <= cprod_nxt;
    rbits_r <= rbits_nxt;
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
  end

  a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
    push_o |-> (state_r == F_PUSH))
    else $error("push outside push state");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> (rem_r < divisor))
    else $error("noise remainder out of range");

endmodule

[hw/rtl/gpg_back.sv]
// ----------------------------------------------------------------------------
// gpg_back
// Normalizes projection to t, blends the colors, adds noise, clamps.
// ----------------------------------------------------------------------------
module gpg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            empty_i,
  output logic            pop_o,
  input  gpg_pkg::entry_t entry_i,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic            out_end_of_line,
  output logic            out_end_of_frame
);

  localparam int PW = gpg_pkg::PROJ_W;
  localparam int TW = gpg_pkg::T_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIV  = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_SUM  = 3'd3;
  localparam logic [2:0] B_OUT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  gpg_pkg::entry_t       e_r, e_nxt;
  logic [PW-1:0]         rem_r, rem_nxt;
  logic [TW-1:0]         t_r, t_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic                  sat_r, sat_nxt;
  logic signed [35:0]    prod_r [3];
  logic signed [35:0]    prod_nxt [3];
  logic                  valid_r, valid_nxt;
  logic [2:0][7:0]       ch_r, ch_nxt;
  logic                  eol_r, eol_nxt, eof_r, eof_nxt;

  logic [PW:0]           rem2, rng_e;
  logic                  ge;
  logic signed [35:0]    diff_e, t_e;
  logic signed [39:0]    v;
  logic signed [17:0]    chv;

  assign rng_e = {1'b0, e_r.rng};
  assign rem2  = {rem_r, 1'b0};
  assign ge    = (rem2 >= rng_e);
  assign pop_o = (state_r == B_IDLE) && !empty_i;

  always_comb begin
    state_nxt = state_r;
    e_nxt     = e_r;
    rem_nxt   = rem_r;
    t_nxt     = t_r;
    cnt_nxt   = cnt_r;
    sat_nxt   = sat_r;
    valid_nxt = valid_r;
    ch_nxt    = ch_r;
    eol_nxt   = eol_r;
    eof_nxt   = eof_r;
    diff_e    = '0;
    t_e       = '0;
    v         = '0;
    chv       = '0;
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = prod_r[i];
    end
    unique case (state_r)
      B_IDLE: begin
        if (!empty_i) begin
          e_nxt     = entry_i;
          rem_nxt   = entry_i.num;
          sat_nxt   = (entry_i.num >= entry_i.rng);
          t_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        // one quotient bit per cycle; at or past the range t is one
        if (sat_r) begin
          t_nxt     = TW'(65536);
          state_nxt = B_MUL;
        end else begin
          rem_nxt = ge ? PW'(rem2 - rng_e) : PW'(rem2);
          t_nxt   = {t_r[TW-2:0], ge};
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'(gpg_pkg::DIV_STEPS - 1)) begin
            state_nxt = B_MUL;
          end
        end
      end
      B_MUL: begin
        for (int i = 0; i < 3; i++) begin
          diff_e = 36'($signed(e_r.bot[i])) - 36'($signed(e_r.top[i]));
          t_e    = 36'(t_r);
          prod_nxt[i] = diff_e * t_e;
        end
        state_nxt = B_SUM;
      end
      B_SUM: begin
        for (int i = 0; i < 3; i++) begin
          v = $signed({24'(signed'(e_r.top[i])), 16'd0}) + 40'(prod_r[i]);
          if (v < 0) v = '0;
          chv = $signed({2'b0, v[39:24]}) + 18'($signed(e_r.noise));
          if (chv < 0) chv = '0;
          else if (chv > 18'sd255) chv = 18'sd255;
          ch_nxt[i] = chv[7:0];
        end
        eol_nxt   = e_r.eol;
        eof_nxt   = e_r.eof;
        valid_nxt = 1'b1;
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_stall) begin
          valid_nxt = 1'b0;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r   <= e_nxt;
    rem_r <= rem_nxt;
    t_r   <= t_nxt;
    cnt_r <= cnt_nxt;
    sat_r <= sat_nxt;
    ch_r  <= ch_nxt;
    eol_r <= eol_nxt;
    eof_r <= eof_nxt;
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= prod_nxt[i];
    end
  end

  assign out_valid        = valid_r;
  assign out_red          = ch_r[0];
  assign out_green        = ch_r[1];
  assign out_blue         = ch_r[2];
  assign out_end_of_line  = eol_r;
  assign out_end_of_frame = eof_r;

  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r == (state_r == B_OUT))
    else $error("result valid outside output state");
  a_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MUL) |-> (t_r <= TW'(65536)))
    else $error("t above one");

endmodule

[hw/rtl/gradient_pixel_generator_top.sv]
// ----------------------------------------------------------------------------
// gradient_pixel_generator_top
// Linear-gradient RGB pixel source with day palette and grain noise.
//
//   channel  direction  handshake           payload
//   in       in         in_valid/in_stall   in_frame_start
//   out      out        out_valid/out_stall red, green, blue, end_of_line/frame
//   cfg      in         cfg_we              cfg_index, cfg_data
//
// A plain pixel passes through the front (transfer, products, 15-step noise
// remainder, push) and then the back (pop, 16-step t divider, blend, sum,
// output). A t at or past one skips the divider. A frame start adds a setup
// pass in the front for colors and extent. Front and back overlap through a
// two-entry queue, so throughput is set by the back, which pops a new pixel
// only after its last result has left the output register. Reset is
// synchronous; no clearing pass. A stalled result holds in the output
// register while the front keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module gradient_pixel_generator_top #(
  parameter int MAX_WIDTH  = gpg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gpg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [gpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gpg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             out_end_of_line,
  output logic                             out_end_of_frame
);

  gpg_pkg::cfg_t   cfg_r, cfg_nxt;
  gpg_pkg::entry_t q_in, q_out;
  logic            push, pop, full, empty;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        gpg_pkg::CFG_TIME:   cfg_nxt.time_of_day  = cfg_data[12:0];
        gpg_pkg::CFG_GRAIN:  cfg_nxt.grain        = cfg_data[4:0];
        gpg_pkg::CFG_DIR_X:  cfg_nxt.dir_x        = cfg_data;
        gpg_pkg::CFG_DIR_Y:  cfg_nxt.dir_y        = cfg_data;
        gpg_pkg::CFG_WIDTH:  cfg_nxt.frame_width  = cfg_data[11:0];
        gpg_pkg::CFG_HEIGHT: cfg_nxt.frame_height = cfg_data[11:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_of_day  <= gpg_pkg::RST_TIME;
      cfg_r.grain        <= gpg_pkg::RST_GRAIN;
      cfg_r.dir_x        <= gpg_pkg::RST_DIR_X;
      cfg_r.dir_y        <= gpg_pkg::RST_DIR_Y;
      cfg_r.frame_width  <= gpg_pkg::RST_WIDTH;
      cfg_r.frame_height <= gpg_pkg::RST_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gpg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_start (in_frame_start),
    .push_o         (push),
    .entry_o        (q_in),
    .full_i         (full)
  );

  gpg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (q_out),
    .empty_o (empty)
  );

  gpg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty_i          (empty),
    .pop_o            (pop),
    .entry_i          (q_out),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

[bench/tb_gradient_pixel_generator_top.sv]
// ----------------------------------------------------------------------------
// tb_gradient_pixel_generator_top
// Self-checking bench for the gradient pixel generator. A built-in predictor
// tracks raster position, noise seed, frame colors and projection extent,
// and computes every pixel. Directed phases cover the reset state, palette
// segments, extent corners and size edges. Random phases follow. Both channels
// idle in random bursts, except in the last random phases.
// ----------------------------------------------------------------------------
module tb_gradient_pixel_generator_top;

  localparam int MAXW = gpg_pkg::DEF_MAX_WIDTH;
  localparam int MAXH = gpg_pkg::DEF_MAX_HEIGHT;
  localparam int IW = gpg_pkg::CFG_IDX_W;
  localparam int DW = gpg_pkg::CFG_DATA_W;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eol;
    logic       eof;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic out_end_of_line, out_end_of_frame;

  gradient_pixel_generator_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_end_of_line(out_end_of_line), .out_end_of_frame(out_end_of_frame)
  );

  always #4 clk = ~clk;

  // predictor copy of registers and state
  logic [12:0] m_time = gpg_pkg::RST_TIME;
  logic [4:0]  m_grain = gpg_pkg::RST_GRAIN;
  logic [15:0] m_dx = gpg_pkg::RST_DIR_X;
  logic [15:0] m_dy = gpg_pkg::RST_DIR_Y;
  logic [11:0] m_width = gpg_pkg::RST_WIDTH;
  logic [11:0] m_height = gpg_pkg::RST_HEIGHT;
  int unsigned m_col = 0, m_row = 0;
  int unsigned m_seed = 1337;
  int m_top[3] = '{0, 0, 0};
  int m_bot[3] = '{0, 0, 0};
  longint m_pmin = 0, m_prange = 16384;

  int pal_top[4][3] = '{'{10, 10, 25}, '{200, 100, 80}, '{100, 200, 255}, '{80, 40, 100}};
  int pal_bot[4][3] = '{'{5, 5, 15}, '{100, 50, 60}, '{180, 230, 255}, '{250, 120, 80}};

  pixel_t pending_pixels[$];
  int errors = 0;
  bit idle_on = 1'b1;
  int idle_left = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic int unsigned clip_size(logic [11:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // recompute colors and extent at frame start
  function automatic void start_frame(int unsigned w, int unsigned h);
    int unsigned tm, seg, nxt;
    int f;
    longint cx, cy, cxy, mn, mx;
    tm = (m_time > 6144) ? 6144 : 32'(m_time);
    seg = tm / 1536;
    if (seg > 3) seg = 3;
    f = tm - seg * 1536;
    nxt = (seg + 1) % 4;
    for (int i = 0; i < 3; i++) begin
      m_top[i] = pal_top[seg][i] * 256 + ((pal_top[nxt][i] - pal_top[seg][i]) * f) / 6;
      m_bot[i] = pal_bot[seg][i] * 256 + ((pal_bot[nxt][i] - pal_bot[seg][i]) * f) / 6;
    end
    cx = longint'(w) * longint'($signed(m_dx));
    cy = longint'(h) * longint'($signed(m_dy));
    cxy = cx + cy;
    mn = 0;
    mx = 0;
    if (cx < mn) mn = cx;
    if (cy < mn) mn = cy;
    if (cxy < mn) mn = cxy;
    if (cx > mx) mx = cx;
    if (cy > mx) mx = cy;
    if (cxy > mx) mx = cxy;
    m_pmin = mn;
    m_prange = mx - mn;
    if (m_prange < 2) m_prange = 16384;
    m_seed = 1337;
  endfunction

  // compute the pixel for one transfer and advance the raster
  function automatic void predict_pixel(logic fs);
    int unsigned w, h, r;
    longint p, t, v;
    int noise, ch;
    pixel_t px;
    int chans[3];
    w = clip_size(m_width, MAXW);
    h = clip_size(m_height, MAXH);
    noise = 0;
    if (fs) begin
      start_frame(w, h);
      m_col = 0;
      m_row = 0;
    end
    p = longint'(m_col) * longint'($signed(m_dx)) + longint'(m_row) * longint'($signed(m_dy));
    if (p <= m_pmin) begin
      t = 0;
    end else begin
      t = ((p - m_pmin) * 65536) / m_prange;
      if (t > 65536) t = 65536;
    end
    if (m_grain > 0) begin
      m_seed = m_seed * 32'd1103515245 + 32'd12345;
      r = (m_seed >> 16) & 32767;
      noise = int'(r % (2 * m_grain + 1)) - int'(m_grain);
    end
    for (int i = 0; i < 3; i++) begin
      v = longint'(m_top[i]) * 65536 + longint'(m_bot[i] - m_top[i]) * t;
      if (v < 0) v = 0;
      ch = int'(v >>> 24) + noise;
      if (ch < 0) ch = 0;
      if (ch > 255) ch = 255;
      chans[i] = ch;
    end
    px.red = 8'(chans[0]);
    px.green = 8'(chans[1]);
    px.blue = 8'(chans[2]);
    px.eol = (m_col >= w - 1);
    px.eof = px.eol && (m_row >= h - 1);
    pending_pixels.push_back(px);
    if (px.eol) begin
      m_col = 0;
      m_row = px.eof ? 0 : m_row + 1;
    end else begin
      m_col++;
    end
  endfunction

  // send one request; hold until transfer, then maybe idle
  task automatic send_request(logic fs);
    int gap;
    in_valid <= 1'b1;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    predict_pixel(fs);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      in_frame_start <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every pixel is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IW-1:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      gpg_pkg::CFG_TIME:   m_time = data[12:0];
      gpg_pkg::CFG_GRAIN:  m_grain = data[4:0];
      gpg_pkg::CFG_DIR_X:  m_dx = data;
      gpg_pkg::CFG_DIR_Y:  m_dy = data;
      gpg_pkg::CFG_WIDTH:  m_width = data[11:0];
      gpg_pkg::CFG_HEIGHT: m_height = data[11:0];
      default: ;
    endcase
  endtask

  // write all registers; block must be idle
  task automatic configure(int tm, int g, int dx, int dy, int w, int h);
    drain();
    write_reg(gpg_pkg::CFG_TIME, 16'(tm));
    write_reg(gpg_pkg::CFG_GRAIN, 16'(g));
    write_reg(gpg_pkg::CFG_DIR_X, 16'(dx));
    write_reg(gpg_pkg::CFG_DIR_Y, 16'(dy));
    write_reg(gpg_pkg::CFG_WIDTH, 16'(w));
    write_reg(gpg_pkg::CFG_HEIGHT, 16'(h));
    cfg_we <= 1'b0;
    cfg_data <= DW'($urandom);
  endtask

  task automatic send_run(int n, int fs_odds);
    for (int i = 0; i < n; i++) send_request(fs_odds > 0 && $urandom_range(1, fs_odds) == 1);
  endtask

  // pixels before any frame start: zero colors, noise only
  task automatic test_reset_state();
    send_run(3, 0);
  endtask

  // palette segments, segment borders and time past a full day
  task automatic test_palette();
    int times[5] = '{0, 1536, 4607, 6144, 8191};
    foreach (times[i]) begin
      configure(times[i], (i == 0) ? 0 : 31, 16384, -16384, 2, 2);
      send_request(1'b1);
      send_run(3, 0);
    end
  endtask

  // zero extent, clamped t, width and height edges, shrink mid-frame
  task automatic test_extent_and_size();
    configure(3000, 30, 0, 0, 0, 0);
    send_request(1'b1);
    send_run(1, 0);
    configure(2000, 1, 32767, 16'h8000, 4095, 4095);
    send_request(1'b1);
    send_run(3, 0);
    configure(5000, 2, 16'hC000, 16384, 8, 3);
    send_request(1'b1);
    send_run(5, 0);
    configure(5000, 2, 16'hC000, 16384, 3, 1);
    send_run(3, 0);
  endtask

  function automatic int pick_dir();
    case ($urandom_range(0, 3))
      0: return 16384;
      1: return 16'hC000;
      2: return 0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // random settings, mostly small frames, occasional large ones
  task automatic test_random();
    int w, h;
    for (int ph = 0; ph < 14; ph++) begin
      if (ph >= 11) idle_on = 1'b0;
      if ($urandom_range(0, 6) == 0) begin
        w = $urandom_range(0, 4095);
        h = $urandom_range(0, 4095);
      end else begin
        w = $urandom_range(0, 7);
        h = $urandom_range(0, 7);
      end
      configure($urandom_range(0, 8191), $urandom_range(0, 31), pick_dir(), pick_dir(), w, h);
      send_request(1'b1);
      send_run(100, 30);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel count", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_end_of_line !== want.eol)
          report_mismatch("end_of_line", out_end_of_line, want.eol);
        if (out_end_of_frame !== want.eof)
          report_mismatch("end_of_frame", out_end_of_frame, want.eof);
      end
    end
  end

  // output stall in random bursts
  always @(posedge clk) begin
    if (idle_left > 0) begin
      idle_left <= idle_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      idle_left <= $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gradient_pixel_generator_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_palette();
    test_extent_and_size();
    test_random();
    drain();
    if (errors == 0) begin
      $display("gradient_pixel_generator_top: match");
    end else begin
      $display("gradient_pixel_generator_top: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/gpg_pkg.sv
hw/rtl/gpg_queue.sv
hw/rtl/gpg_front.sv
hw/rtl/gpg_back.sv
hw/rtl/gradient_pixel_generator_top.sv
bench/tb_gradient_pixel_generator_top.sv
